@@ sv/mqs_pkg.sv @@
package mqs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int POS_BITS = 8;
  localparam int AXES = 4;
  localparam int LEVEL_BITS = 6;
  localparam int LVL_W = (PTR_BITS + 1 > LEVEL_BITS) ? PTR_BITS + 1 : LEVEL_BITS;

  // axis slots inside a tuple
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_THETA = 2;
  localparam int AX_PHI = 3;

  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic [AXES-1:0][POS_BITS-1:0] tuple_t;
  typedef logic [LEVEL_BITS-1:0] level_t;

  typedef enum logic [1:0] {
    ACT_ABS   = 2'd0,
    ACT_REL   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_ABORT = 2'd3
  } action_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = ptr_t'(QUEUE_DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

endpackage

@@ sv/mqs_cmd_if.sv @@
interface mqs_cmd_if;
  import mqs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  pos_t       x;
  pos_t       y;
  pos_t       theta;
  pos_t       phi;

  modport source (output valid, action, x, y, theta, phi, input ready);
  modport sink (input valid, action, x, y, theta, phi, output ready);
endinterface

@@ sv/mqs_res_if.sv @@
interface mqs_res_if;
  import mqs_pkg::*;

  logic   valid;
  logic   ready;
  logic   status;
  logic   moving;
  logic   step_x;
  logic   dir_x;
  logic   step_y;
  logic   dir_y;
  pos_t   pos_x;
  pos_t   pos_y;
  pos_t   pos_theta;
  pos_t   pos_phi;
  level_t queue_level;

  modport source (output valid, status, moving, step_x, dir_x, step_y, dir_y,
                  pos_x, pos_y, pos_theta, pos_phi, queue_level, input ready);
  modport sink (input valid, status, moving, step_x, dir_x, step_y, dir_y,
                pos_x, pos_y, pos_theta, pos_phi, queue_level, output ready);
endinterface

@@ sv/mqs_ring.sv @@
module mqs_ring (
  input  logic            clk,
  input  logic            wr_en,
  input  mqs_pkg::ptr_t   wr_addr,
  input  mqs_pkg::tuple_t wr_data,
  input  mqs_pkg::ptr_t   rd_addr,
  output mqs_pkg::tuple_t rd_data
);
  import mqs_pkg::*;

  tuple_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

@@ sv/four_axis_move_queue_stepper.sv @@
// channel | dir | handshake    | payload
// cmd     | in  | valid, ready | action, x, y, theta, phi
// res     | out | valid, ready | status, moving, step_x, dir_x, step_y, dir_y,
//         |     |              | pos_x, pos_y, pos_theta, pos_phi, queue_level
//
// each item: the accept cycle issues the ring read, then the EXEC state
// uses the registered ring data, updates state and loads the result register
// one item in flight at a time; cmd.ready is high only in the idle state
// a result not yet taken holds EXEC until res.ready frees the register
// rst is synchronous; pointers, positions, directions and busy clear, ring not
module four_axis_move_queue_stepper (
  input  logic     clk,
  input  logic     rst,
  mqs_cmd_if.sink  cmd,
  mqs_res_if.source res
);
  import mqs_pkg::*;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  typedef struct packed {
    action_t action;
    tuple_t  arg;
  } item_t;

  state_t state;
  item_t  item;

  // queue and motion state
  ptr_t      wr_ptr, wr_ptr_next;
  ptr_t      rd_ptr, rd_ptr_next;
  tuple_t    cur_pos, cur_pos_next;
  tuple_t    tgt_pos, tgt_pos_next;
  logic [AXES-1:0] dirs, dirs_next;
  logic      busy, busy_next;

  // result register
  logic      res_valid;
  logic      r_status, r_status_next;
  logic [AXES-1:0] r_step, r_step_next;
  logic [AXES-1:0] r_dir, r_dir_next;
  level_t    r_level, r_level_next;

  // ring port signals
  logic      ring_we;
  tuple_t    ring_wdata;
  ptr_t      ring_raddr;
  tuple_t    ring_rdata;
  action_t   rd_action;

  logic      finish;
  logic      empty;
  logic      full;
  tuple_t    goal;
  tuple_t    rel_sum;
  logic [LVL_W-1:0] lvl;
  logic signed [POS_BITS:0] wide_sum [AXES];

  assign cmd.ready = (state == IDLE);
  assign finish = (state == EXEC) && (!res_valid || res.ready);

  // read address: live payload on accept, held item while waiting to finish
  assign rd_action = (state == IDLE) ? action_t'(cmd.action) : item.action;
  assign ring_raddr = (rd_action == ACT_REL) ? ptr_dec(wr_ptr) : rd_ptr;

  mqs_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wr_ptr),
    .wr_data (ring_wdata),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (ptr_inc(wr_ptr) == rd_ptr);

  // end goal for relative moves: newest entry, else current target
  assign goal = empty ? tgt_pos : ring_rdata;

  // bounded add: an axis that leaves the signed range keeps its goal
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      wide_sum[i] = {goal[i][POS_BITS-1], goal[i]} + {item.arg[i][POS_BITS-1], item.arg[i]};
      if (wide_sum[i][POS_BITS] != wide_sum[i][POS_BITS-1]) begin
        rel_sum[i] = goal[i];
      end else begin
        rel_sum[i] = wide_sum[i][POS_BITS-1:0];
      end
    end
  end

  always_comb begin
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    cur_pos_next  = cur_pos;
    tgt_pos_next  = tgt_pos;
    dirs_next     = dirs;
    busy_next     = busy;
    r_status_next = 1'b0;
    r_step_next   = '0;
    r_dir_next    = '0;
    ring_we       = 1'b0;
    ring_wdata    = item.arg;

    case (item.action)
      ACT_ABS, ACT_REL: begin
        if (item.action == ACT_REL) begin
          ring_wdata = rel_sum;
        end
        if (full) begin
          r_status_next = 1'b1;
        end else begin
          ring_we     = finish;
          wr_ptr_next = ptr_inc(wr_ptr);
        end
      end
      ACT_TICK: begin
        // idle with entries queued: dequeue and latch directions
        if (!busy && !empty) begin
          tgt_pos_next = ring_rdata;
          rd_ptr_next  = ptr_inc(rd_ptr);
          busy_next    = 1'b1;
          for (int i = 0; i < AXES; i++) begin
            dirs_next[i] = $signed(cur_pos[i]) < $signed(ring_rdata[i]);
          end
        end
        // one unit per unequal axis, move ends when all arrive
        if (busy_next) begin
          for (int i = 0; i < AXES; i++) begin
            if (cur_pos[i] != tgt_pos_next[i]) begin
              r_step_next[i] = 1'b1;
              r_dir_next[i]  = dirs_next[i];
              if (dirs_next[i]) begin
                cur_pos_next[i] = cur_pos[i] + 1'b1;
              end else begin
                cur_pos_next[i] = cur_pos[i] - 1'b1;
              end
            end
          end
          if (cur_pos_next == tgt_pos_next) begin
            busy_next = 1'b0;
          end
        end
      end
      ACT_ABORT: begin
        wr_ptr_next = rd_ptr;
      end
      default: begin
      end
    endcase

    if (wr_ptr_next >= rd_ptr_next) begin
      lvl = LVL_W'(wr_ptr_next) - LVL_W'(rd_ptr_next);
    end else begin
      lvl = LVL_W'(wr_ptr_next) + LVL_W'(QUEUE_DEPTH) - LVL_W'(rd_ptr_next);
    end
    r_level_next = lvl[LEVEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      cur_pos   <= '0;
      tgt_pos   <= '0;
      dirs      <= '0;
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken at this edge
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.valid) begin
            item.action <= action_t'(cmd.action);
            item.arg[AX_X]     <= cmd.x;
            item.arg[AX_Y]     <= cmd.y;
            item.arg[AX_THETA] <= cmd.theta;
            item.arg[AX_PHI]   <= cmd.phi;
            state <= EXEC;
          end
        end
        EXEC: begin
          if (finish) begin
            wr_ptr    <= wr_ptr_next;
            rd_ptr    <= rd_ptr_next;
            cur_pos   <= cur_pos_next;
            tgt_pos   <= tgt_pos_next;
            dirs      <= dirs_next;
            busy      <= busy_next;
            r_status  <= r_status_next;
            r_step    <= r_step_next;
            r_dir     <= r_dir_next;
            r_level   <= r_level_next;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // result fields; positions come straight from the live state, which only
  // changes when a new result is loaded
  assign res.valid       = res_valid;
  assign res.status      = r_status;
  assign res.moving      = busy;
  assign res.step_x      = r_step[AX_X];
  assign res.dir_x       = r_dir[AX_X];
  assign res.step_y      = r_step[AX_Y];
  assign res.dir_y       = r_dir[AX_Y];
  assign res.pos_x       = cur_pos[AX_X];
  assign res.pos_y       = cur_pos[AX_Y];
  assign res.pos_theta   = cur_pos[AX_THETA];
  assign res.pos_phi     = cur_pos[AX_PHI];
  assign res.queue_level = r_level;
endmodule

@@ tb/sv/four_axis_move_queue_stepper_test.sv @@
module four_axis_move_queue_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mqs_pkg::*;

  // long receiver hold-off, in clock cycles
  localparam int HOLD_CYCLES = 300;
  // random stimulus size, in command items
  localparam int RANDOM_ITEMS = 840;
  // signed position range at the block's width
  localparam int POS_HI = (1 << (POS_BITS - 1)) - 1;
  localparam int POS_LO = -(1 << (POS_BITS - 1));

  // one command item as offered on the cmd channel
  typedef struct {
    action_t act;
    pos_t    axis[AXES];
  } move_cmd_t;

  // one result item as expected on the res channel
  typedef struct {
    logic   status;
    logic   moving;
    logic   step_x;
    logic   dir_x;
    logic   step_y;
    logic   dir_y;
    pos_t   pos[AXES];
    level_t level;
  } step_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mqs_cmd_if cmd ();
  mqs_res_if res ();

  four_axis_move_queue_stepper uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // motion predictor: own copy of the move ring, pointers, positions and the
  // latched per-axis directions; updated once per accepted command item
  // ---------------------------------------------------------------------------
  pos_t queued_moves [QUEUE_DEPTH][AXES];
  int   wr_idx;
  int   rd_idx;
  pos_t cur_pos [AXES];
  pos_t tgt_pos [AXES];
  logic [AXES-1:0] axis_up;
  logic stepper_busy;

  // results still owed by the block, oldest first
  step_report_t expected_reports[$];

  int   errors = 0;
  int   results_seen = 0;
  int   cmds_sent = 0;
  int   refused_adds = 0;
  int   burst_left = 0;
  int   hold_request = 0;
  logic drain_out = 1'b0;

  function automatic int queue_level_now();
    return (wr_idx + QUEUE_DEPTH - rd_idx) % QUEUE_DEPTH;
  endfunction

  // newest queued target, or the running target when nothing is queued
  function automatic pos_t end_goal(input int ax);
    if (wr_idx != rd_idx) begin
      return queued_moves[(wr_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH][ax];
    end
    return tgt_pos[ax];
  endfunction

  function automatic void advance_stepper_model(input move_cmd_t c);
    step_report_t    r;
    pos_t            goal [AXES];
    int              sum;
    logic [AXES-1:0] stepped;
    logic            arrived;
    r.status = 1'b0;
    stepped = '0;
    case (c.act)
      ACT_ABS, ACT_REL: begin
        for (int ax = 0; ax < AXES; ax++) begin
          goal[ax] = c.axis[ax];
          if (c.act == ACT_REL) begin
            sum = int'(end_goal(ax)) + int'(c.axis[ax]);
            // an axis that would leave the range keeps its end goal
            goal[ax] = (sum > POS_HI || sum < POS_LO) ? end_goal(ax) : pos_t'(sum);
          end
        end
        // ring keeps one slot free, so depth minus one entries means full
        if ((wr_idx + 1) % QUEUE_DEPTH == rd_idx) begin
          r.status = 1'b1;
        end else begin
          for (int ax = 0; ax < AXES; ax++) queued_moves[wr_idx][ax] = goal[ax];
          wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
        end
      end
      ACT_TICK: begin
        // idle with work queued: pull the oldest target and latch directions
        if (!stepper_busy && wr_idx != rd_idx) begin
          for (int ax = 0; ax < AXES; ax++) begin
            tgt_pos[ax] = queued_moves[rd_idx][ax];
            axis_up[ax] = (cur_pos[ax] < tgt_pos[ax]);
          end
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          stepper_busy = 1'b1;
        end
        // every moving tick, the first one too, steps each unequal axis
        if (stepper_busy) begin
          arrived = 1'b1;
          for (int ax = 0; ax < AXES; ax++) begin
            if (cur_pos[ax] != tgt_pos[ax]) begin
              stepped[ax] = 1'b1;
              cur_pos[ax] = axis_up[ax] ? cur_pos[ax] + 1'b1 : cur_pos[ax] - 1'b1;
            end
            if (cur_pos[ax] != tgt_pos[ax]) arrived = 1'b0;
          end
          if (arrived) stepper_busy = 1'b0;
        end
      end
      ACT_ABORT: begin
        // drop everything queued, a running move carries on
        wr_idx = rd_idx;
      end
    endcase
    r.moving = stepper_busy;
    r.step_x = stepped[AX_X];
    r.dir_x  = stepped[AX_X] & axis_up[AX_X];
    r.step_y = stepped[AX_Y];
    r.dir_y  = stepped[AX_Y] & axis_up[AX_Y];
    for (int ax = 0; ax < AXES; ax++) r.pos[ax] = cur_pos[ax];
    r.level = level_t'(queue_level_now());
    expected_reports.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [POS_BITS-1:0] got,
                             input logic [POS_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name,
                                got, want));
    end
  endtask

  // results are taken at the rising edge where valid and ready are both high
  always @(posedge clk) begin : check_results
    step_report_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result item with nothing outstanding");
      end else begin
        want = expected_reports.pop_front();
        check_field("status", res.status, want.status);
        check_field("moving", res.moving, want.moving);
        check_field("step_x", res.step_x, want.step_x);
        check_field("dir_x", res.dir_x, want.dir_x);
        check_field("step_y", res.step_y, want.step_y);
        check_field("dir_y", res.dir_y, want.dir_y);
        check_field("pos_x", res.pos_x, want.pos[AX_X]);
        check_field("pos_y", res.pos_y, want.pos[AX_Y]);
        check_field("pos_theta", res.pos_theta, want.pos[AX_THETA]);
        check_field("pos_phi", res.pos_phi, want.pos[AX_PHI]);
        check_field("queue_level", res.queue_level, want.level);
      end
      if (res.status === 1'b1) refused_adds++;
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: stalls in segments of random length, each with its own
  // stall rate (zero included), plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left = 0;
    stall_pct = 0;
    hold_left = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res.ready = 1'b0;
        hold_left--;
      end else if (drain_out) begin
        res.ready = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        res.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command sender
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at a falling edge; valid stays high
  // inside a burst and, after most bursts, drops for a random gap
  task automatic send_move(input move_cmd_t c);
    cmd.valid = 1'b1;
    cmd.action = c.act;
    cmd.x = c.axis[AX_X];
    cmd.y = c.axis[AX_Y];
    cmd.theta = c.axis[AX_THETA];
    cmd.phi = c.axis[AX_PHI];
    do @(posedge clk); while (cmd.ready !== 1'b1);
    advance_stepper_model(c);
    cmds_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        // junk on the payload while valid is low
        cmd.valid = 1'b0;
        cmd.action = action_t'($urandom_range(0, 3));
        cmd.x = pos_t'($urandom);
        cmd.y = pos_t'($urandom);
        cmd.theta = pos_t'($urandom);
        cmd.phi = pos_t'($urandom);
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  function automatic move_cmd_t make_move(input action_t a, input int px, input int py,
                                          input int pt, input int pp);
    move_cmd_t c;
    c.act = a;
    c.axis[AX_X] = pos_t'(px);
    c.axis[AX_Y] = pos_t'(py);
    c.axis[AX_THETA] = pos_t'(pt);
    c.axis[AX_PHI] = pos_t'(pp);
    return c;
  endfunction

  // ticks, aborts and moves: mostly short moves near the end goal and small
  // offsets, with some full-range targets and offsets that run into the range limits
  function automatic move_cmd_t random_move();
    move_cmd_t c;
    int r;
    int v;
    r = $urandom_range(0, 99);
    // a long queue gets worked down by ticks
    if (queue_level_now() >= 8 && r < 70) r = 0;
    for (int ax = 0; ax < AXES; ax++) c.axis[ax] = pos_t'($urandom);
    if (r < 45) begin
      c.act = ACT_TICK;
    end else if (r < 65) begin
      c.act = ACT_ABS;
      if ($urandom_range(0, 9) != 0) begin
        for (int ax = 0; ax < AXES; ax++) begin
          v = int'(end_goal(ax)) + int'($urandom_range(0, 12)) - 6;
          if (v > POS_HI) v = POS_HI;
          if (v < POS_LO) v = POS_LO;
          c.axis[ax] = pos_t'(v);
        end
      end
    end else if (r < 88) begin
      c.act = ACT_REL;
      if ($urandom_range(0, 7) != 0) begin
        for (int ax = 0; ax < AXES; ax++) c.axis[ax] = pos_t'(int'($urandom_range(0, 8)) - 4);
      end
    end else if (r < 93) begin
      c.act = ACT_ABORT;
    end else begin
      c.act = action_t'($urandom_range(0, 3));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // tick and abort on an empty idle block, then a target equal to the
  // current position, which ends on its first tick without a step
  task automatic test_idle_and_zero_move();
    send_move(make_move(ACT_TICK, 0, 0, 0, 0));
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    send_move(make_move(ACT_ABS, 0, 0, 0, 0));
    send_move(make_move(ACT_TICK, 0, 0, 0, 0));
  endtask

  // two short moves in both directions on every axis, the second one
  // relative to the first queued target
  task automatic test_short_moves();
    send_move(make_move(ACT_ABS, 2, -2, 1, -1));
    send_move(make_move(ACT_REL, -3, 3, -1, 1));
    repeat (6) send_move(make_move(ACT_TICK, 0, 0, 0, 0));
  endtask

  // field extremes and relative sums that leave the range on some axes;
  // a relative add on an empty queue builds on the running target
  task automatic test_relative_overflow();
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    send_move(make_move(ACT_ABS, POS_HI, POS_LO, POS_LO, POS_HI));
    send_move(make_move(ACT_REL, 1, -1, POS_HI, POS_LO));
    send_move(make_move(ACT_REL, POS_LO, POS_HI, 0, 0));
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    send_move(make_move(ACT_REL, 5, -5, 3, -3));
  endtask

  // abort while a move runs: the queue empties, the move goes on
  task automatic test_abort_mid_move();
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    send_move(make_move(ACT_ABS, 20, -20, 20, -20));
    send_move(make_move(ACT_ABS, 0, 0, 0, 0));
    send_move(make_move(ACT_TICK, 0, 0, 0, 0));
    send_move(make_move(ACT_TICK, 0, 0, 0, 0));
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    send_move(make_move(ACT_TICK, 0, 0, 0, 0));
  endtask

  // fill the ring to depth minus one, then two adds that must be refused
  task automatic test_full_queue();
    move_cmd_t c;
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
    repeat (QUEUE_DEPTH + 1) begin
      c = random_move();
      c.act = ($urandom_range(0, 1) != 0) ? ACT_ABS : ACT_REL;
      send_move(c);
    end
    repeat (3) send_move(make_move(ACT_TICK, 0, 0, 0, 0));
    send_move(make_move(ACT_ABORT, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    int n;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 399) == 0) begin
        test_full_queue();
        n += QUEUE_DEPTH + 5;
      end else begin
        send_move(random_move());
        n++;
      end
    end
  endtask

  // receiver holds off for a long stretch while commands keep coming,
  // so the block sits on a result and stops taking commands
  task automatic test_receiver_hold();
    cmd.valid = 1'b0;
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    repeat (16) send_move(random_move());
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    cmd.valid = 1'b0;
    cmd.action = ACT_TICK;
    cmd.x = '0;
    cmd.y = '0;
    cmd.theta = '0;
    cmd.phi = '0;
    wr_idx = 0;
    rd_idx = 0;
    for (int ax = 0; ax < AXES; ax++) begin
      cur_pos[ax] = '0;
      tgt_pos[ax] = '0;
    end
    axis_up = '0;
    stepper_busy = 1'b0;

    // synchronous reset, released at a falling edge
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_idle_and_zero_move();
    test_short_moves();
    test_relative_overflow();
    test_abort_mid_move();
    test_random_traffic();
    test_full_queue();
    test_receiver_hold();

    // let every owed result come out, then watch a little longer for extras
    cmd.valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    drain_out = 1'b1;
    repeat (16) @(posedge clk);

    $display("covered %0d commands and %0d results, %0d adds refused on a full queue",
             cmds_sent, results_seen, refused_adds);
    $display("receiver held off %0d cycles with commands waiting", HOLD_CYCLES);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results still owed", expected_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
